// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge out of reset
`define AOG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aog assertion failed");
// next-cycle implication
`define AOG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aog assertion failed");
`else
`define AOG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AOG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/aog_pkg.sv -----
// types and constants of the alpha outline generator
// no dependencies; used by every module of the block
package aog_pkg;

    localparam int COL_W     = 12;
    localparam int ROW_W     = 13;
    localparam int DIM_W     = 13;
    localparam int ALPHA_W   = 8;
    localparam int IDX_W     = 2;
    localparam int LIMIT_DIM = 4096;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd64;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd64;
    localparam logic [ALPHA_W-1:0] RST_THRESH = 8'd192;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [ALPHA_W-1:0] thresh;
    } t_geom;

    // one line memory entry: alpha of the two rows above, edge flags of the second and third rows above
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_r1;
        logic [ALPHA_W-1:0] alpha_r2;
        logic               edge_r2;
        logic               edge_r3;
    } t_ent;

    // item handed from the scan stage to the edge stage
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ALPHA_W-1:0] alpha;
        logic               do_edge;
        logic               do_win;
        logic               use_up;
        logic               use_e3;
        logic               has_lf;
        logic               has_rt;
        logic               emit_last;
        logic               frame_end;
        logic [COL_W-1:0]   out_col;
        logic [COL_W-1:0]   out_row;
    } t_item;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_ent             data;
    } t_wr;

endpackage

// ----- src/alpha_outline_generator_top.sv -----
// top level of the alpha outline generator: config registers, scan, line memory, edge stage
// depends on aog_pkg, assert_macros.svh, aog_scan, aog_line_mem, aog_edge
//
// channel   dir  handshake          payload
// pixel     in   i_valid / o_stall  i_mode, i_alpha
// result    out  o_valid / i_stall  o_outline, o_out_col, o_out_row, o_frame_end
// config    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// one item per cycle while not stalled; results pass edge stage and result registers
// the rate is set by the line memory: one read a column ahead, one write-back per item
// synchronous reset clears counters and valid flags, presets config and geometry only
// line memory is not cleared and needs no clearing pass; it is filled by row 0
// a blocked result holds the edge stage, which then stalls the pixel side
`include "assert_macros.svh"
module alpha_outline_generator_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [aog_pkg::ALPHA_W-1:0] i_alpha,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_outline,
    output logic [aog_pkg::COL_W-1:0]   o_out_col,
    output logic [aog_pkg::COL_W-1:0]   o_out_row,
    output logic                        o_frame_end,
    // config port
    input  logic                        i_cfg_we,
    input  logic [aog_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [aog_pkg::DIM_W-1:0]   i_cfg_data
);
    import aog_pkg::*;

    // usable width: the smaller of the parameter and the coordinate limit
    localparam int LIM_W = (MAX_WIDTH < LIMIT_DIM) ? MAX_WIDTH : LIMIT_DIM;
    localparam int AW    = (LIM_W > 1) ? $clog2(LIM_W) : 1;

    t_geom            r_cfg;
    t_geom            geom;
    t_item            item;
    t_ent             rd_ent;
    t_wr              wr;
    logic             accept, proc, busy;
    logic [COL_W-1:0] rd_addr;

    // config registers: user writes only while idle, unenforced; taken at next frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.thresh <= RST_THRESH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_THRESH: r_cfg.thresh <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input side stalls only while the edge stage holds an item it cannot pass on
    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    aog_scan #(
        .LIM_W (LIM_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .i_alpha   (i_alpha),
        .o_proc    (proc),
        .o_item    (item),
        .o_geom    (geom),
        .o_rd_addr (rd_addr)
    );

    // entry per column: alpha of rows r-1, r-2 and edge flags of rows r-2, r-3
    aog_line_mem #(
        .DEPTH (LIM_W),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (proc),
        .i_raddr (rd_addr[AW-1:0]),
        .i_we    (wr.en),
        .i_waddr (wr.addr[AW-1:0]),
        .i_wdata (wr.data),
        .o_rdata (rd_ent)
    );

    aog_edge u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (proc),
        .i_item      (item),
        .i_thresh    (geom.thresh),
        .i_rd_ent    (rd_ent),
        .i_stall     (i_stall),
        .o_busy      (busy),
        .o_wr        (wr),
        .o_valid     (o_valid),
        .o_outline   (o_outline),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_frame_end (o_frame_end)
    );

    // the edge stage only blocks behind a result that is itself stalled
    `AOG_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // a blocked result is still shown in the next cycle
    `AOG_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_stall, o_valid)
    // read and write-back meet at one column only in a two-pixel-wide frame
    `AOG_ASSERT_IMP(a_fwd_narrow, i_clk, i_rst_n, proc && wr.en && (rd_addr == wr.addr), geom.width == 13'd2)

endmodule

// ----- src/aog_line_mem.sv -----
// line memory: one entry per column, one read and one write port
// depends on aog_pkg for the entry type
module aog_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  aog_pkg::t_ent i_wdata,
    output aog_pkg::t_ent o_rdata
);
    import aog_pkg::*;

    t_ent r_mem [0:DEPTH-1];
    t_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // same-address write in the read cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/aog_scan.sv -----
// scan stage: frame position counters, geometry latch, drain handling
// depends on aog_pkg; feeds aog_edge and the line memory read port
module aog_scan #(
    parameter int LIM_W = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aog_pkg::t_geom               i_cfg,
    input  logic                         i_accept,
    input  logic                         i_mode,
    input  logic [aog_pkg::ALPHA_W-1:0]  i_alpha,
    output logic                         o_proc,
    output aog_pkg::t_item               o_item,
    output aog_pkg::t_geom               o_geom,
    output logic [aog_pkg::COL_W-1:0]    o_rd_addr
);
    import aog_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_geom            r_geom;

    logic             frame_start;
    logic [COL_W:0]   col1;
    logic [DIM_W-1:0] fh1, fh2, w1;
    logic             has_rt, done, emit_last;
    logic [ROW_W-1:0] row2, row3;

    function automatic t_geom clamp_geom(input t_geom g);
        t_geom c;
        c = g;
        if (g.width < 13'd2) c.width = 13'd2;
        if (g.width > DIM_W'(LIM_W)) c.width = DIM_W'(LIM_W);
        if (g.height == '0) c.height = 13'd1;
        if (g.height > DIM_W'(LIMIT_DIM)) c.height = DIM_W'(LIMIT_DIM);
        return c;
    endfunction

    always_comb begin
        frame_start = (r_col == '0) && (r_row == '0);
        // a drain tick while pixels are still due is dropped
        o_proc      = i_accept && !(i_mode && (r_row < r_geom.height));
        col1        = {1'b0, r_col} + 13'd1;
        has_rt      = col1 < r_geom.width;
        fh1         = r_geom.height + 13'd1;
        fh2         = r_geom.height + 13'd2;
        w1          = r_geom.width - 13'd1;
        row2        = r_row - 13'd2;
        row3        = r_row - 13'd3;
        done        = r_row >= fh2;
        emit_last   = (r_col == '0) && (r_row >= 13'd3);

        o_item.col       = r_col;
        o_item.alpha     = (r_row < r_geom.height) ? i_alpha : '0;
        o_item.do_edge   = (r_row != '0) && (r_row <= r_geom.height);
        o_item.do_win    = (r_row >= 13'd2) && (r_row <= fh1);
        o_item.use_up    = r_row >= 13'd2;
        o_item.use_e3    = r_row >= 13'd3;
        o_item.has_lf    = r_col != '0;
        o_item.has_rt    = has_rt;
        o_item.emit_last = emit_last;
        o_item.frame_end = emit_last && (r_row == fh2);
        o_item.out_col   = emit_last ? w1[COL_W-1:0] : (r_col - 12'd1);
        o_item.out_row   = emit_last ? row3[COL_W-1:0] : row2[COL_W-1:0];

        // prefetch the next column of the line memory
        o_rd_addr = has_rt ? col1[COL_W-1:0] : '0;

        n_col = r_col;
        n_row = r_row;
        if (done) begin
            n_col = '0;
            n_row = '0;
        end else if (!has_rt) begin
            n_col = '0;
            n_row = r_row + 13'd1;
        end else begin
            n_col = col1[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_geom <= clamp_geom('{width: RST_WIDTH, height: RST_HEIGHT, thresh: RST_THRESH});
        end else if (o_proc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (frame_start) begin
                r_geom <= clamp_geom(i_cfg);
            end
        end
    end

    assign o_geom = r_geom;

endmodule

// ----- src/aog_edge.sv -----
// edge stage: edge test, 3x3 dilation window, line memory write-back, result register
// depends on aog_pkg; fed by aog_scan and aog_line_mem
module aog_edge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  aog_pkg::t_item              i_item,
    input  logic [aog_pkg::ALPHA_W-1:0] i_thresh,
    input  aog_pkg::t_ent               i_rd_ent,
    input  logic                        i_stall,
    output logic                        o_busy,
    output aog_pkg::t_wr                o_wr,
    output logic                        o_valid,
    output logic                        o_outline,
    output logic [aog_pkg::COL_W-1:0]   o_out_col,
    output logic [aog_pkg::COL_W-1:0]   o_out_row,
    output logic                        o_frame_end
);
    import aog_pkg::*;

    logic             r_s1_vld;
    t_item            r_s1;
    t_ent             r_cur;
    logic [ALPHA_W-1:0] r_lf;
    logic             r_win1, r_win2;
    logic             r_o_vld, r_o_bit, r_o_end;
    logic [COL_W-1:0] r_o_col, r_o_row;

    logic [ALPHA_W-1:0] c, lf, rt, up, dn;
    logic             is_edge, vert, emit_mid, emits, adv, res_bit;

    always_comb begin
        c  = r_cur.alpha_r1;
        lf = r_s1.has_lf ? r_lf : '0;
        rt = r_s1.has_rt ? i_rd_ent.alpha_r1 : '0;
        up = r_s1.use_up ? r_cur.alpha_r2 : '0;
        dn = r_s1.alpha;
        is_edge = r_s1.do_edge && (c > i_thresh)
                  && ((lf <= i_thresh) || (rt <= i_thresh) || (up <= i_thresh)
                      || (dn <= i_thresh));
        vert     = is_edge | r_cur.edge_r2 | (r_s1.use_e3 & r_cur.edge_r3);
        emit_mid = r_s1.do_win && r_s1.has_lf;
        emits    = r_s1.emit_last || emit_mid;
        res_bit  = r_s1.emit_last ? (r_win1 | r_win2) : (r_win1 | r_win2 | vert);
        adv      = r_s1_vld && (!emits || !r_o_vld || !i_stall);
        o_busy   = r_s1_vld && !adv;

        o_wr.en            = adv;
        o_wr.addr          = r_s1.col;
        o_wr.data.alpha_r1 = r_s1.alpha;
        o_wr.data.alpha_r2 = c;
        o_wr.data.edge_r2  = is_edge;
        o_wr.data.edge_r3  = r_cur.edge_r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv && emits) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_item;
        end
        if (adv) begin
            // next column's entry becomes the current one
            r_cur <= i_rd_ent;
            r_lf  <= c;
            if (r_s1.do_win) begin
                r_win2 <= r_s1.has_lf ? r_win1 : 1'b0;
                r_win1 <= vert;
            end
        end
        if (adv && emits) begin
            r_o_bit <= res_bit;
            r_o_col <= r_s1.out_col;
            r_o_row <= r_s1.out_row;
            r_o_end <= r_s1.frame_end;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_outline   = r_o_bit;
    assign o_out_col   = r_o_col;
    assign o_out_row   = r_o_row;
    assign o_frame_end = r_o_end;

endmodule
